@@ hdl/mrcd_pkg.sv @@
package mrcd_pkg;

    localparam int ENABLE_BITS    = 4;
    localparam int MAX_RINGS      = 8;
    localparam int MAX_RESULTS    = 64;
    localparam int RESULT_CNT_W   = 7;
    localparam int OUTSTANDING_W  = 7;
    localparam int CFG_DATA_W     = 8;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_OUTSTANDING_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_ENABLE      = 1'd1;

    localparam logic [7:0] LIMIT_RESET = 8'd128;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    localparam logic [1:0] KIND_READ     = 2'd0;
    localparam logic [1:0] KIND_WRITE    = 2'd1;
    localparam logic [1:0] KIND_FLUSH    = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        RES_ACCEPTED   = 3'd0,
        RES_FULL       = 3'd1,
        RES_DISABLED   = 3'd2,
        RES_DISPATCHED = 3'd3,
        RES_NOTHING    = 3'd4
    } t_result_kind;

    typedef struct packed {
        logic        operation;
        logic [1:0]  queue_index;
        logic [1:0]  command_kind;
        logic [63:0] block_address;
        logic [31:0] block_count;
        logic [31:0] namespace_id;
        logic [15:0] request_tag;
        logic [6:0]  completed_count;
    } t_in_word;

    typedef struct packed {
        t_result_kind result_kind;
        logic [1:0]   source_queue;
        logic [1:0]   issued_kind;
        logic [63:0]  issued_address;
        logic [31:0]  issued_count;
        logic [31:0]  issued_namespace;
        logic [15:0]  issued_tag;
        logic [6:0]   outstanding;
        logic         last;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] address;
        logic [31:0] count;
        logic [31:0] nsid;
        logic [15:0] tag;
    } t_slot;

endpackage

@@ hdl/multi_ring_command_dispatcher_unit.sv @@
// Submit words finish in the cycle they are accepted; the result is loaded into the output
// register on acceptance, and the next word is taken as soon as that register is free.
// A poll word applies its completions when accepted, then per dispatched command reads the
// slot memory (S_PICK) and loads the output (S_DATA); an empty poll loads from S_PICK.
// No word is taken until a poll returns to idle, and a busy output register stalls a load.
// Synchronous active-low reset empties all rings and clears the counters; no memory sweep.
module multi_ring_command_dispatcher_unit #(
    parameter int RING_DEPTH = 16,
    parameter int RING_COUNT = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  mrcd_pkg::t_in_word                     i_in_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output mrcd_pkg::t_out_word                    o_out_word,
    input  logic                                   i_cfg_wr_en,
    input  logic [mrcd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [mrcd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int PTR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int RING_W    = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int MEM_AW    = RING_W + PTR_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_DATA
    } t_state;

    t_state                                  r_state;
    logic [7:0]                              r_limit;
    logic [mrcd_pkg::ENABLE_BITS-1:0]        r_enable;
    logic [PTR_W-1:0]                        r_head [RING_COUNT];
    logic [PTR_W-1:0]                        r_tail [RING_COUNT];
    logic [CNT_W-1:0]                        r_fill [RING_COUNT];
    logic [mrcd_pkg::OUTSTANDING_W-1:0]      r_outstanding;
    logic [mrcd_pkg::RESULT_CNT_W-1:0]       r_dispatched;
    logic [1:0]                              r_src;
    logic                                    r_out_valid;
    mrcd_pkg::t_out_word                     r_out;

    mrcd_pkg::t_slot                         r_mem [MEM_DEPTH];
    mrcd_pkg::t_slot                         r_mem_rdata;

    logic [mrcd_pkg::MAX_RINGS-1:0]          w_en_pad;
    logic [mrcd_pkg::MAX_RINGS-1:0]          w_rise_pad;
    logic [mrcd_pkg::MAX_RINGS-1:0]          w_ring_on;
    logic                                    w_out_free;
    logic                                    w_out_load;
    logic                                    w_accept;
    logic [RING_W-1:0]                       w_q;
    logic                                    w_q_on;
    logic                                    w_q_full;
    logic [RING_W-1:0]                       w_pick;
    logic                                    w_found;
    logic [mrcd_pkg::OUTSTANDING_W-1:0]      w_threshold;
    logic                                    w_can;
    logic                                    w_mem_we;
    logic                                    w_mem_re;
    logic [MEM_AW-1:0]                       w_mem_waddr;
    logic [MEM_AW-1:0]                       w_mem_raddr;
    mrcd_pkg::t_slot                         w_mem_wdata;
    logic [mrcd_pkg::OUTSTANDING_W-1:0]      n_outstanding_sub;
    mrcd_pkg::t_out_word                     n_out;

    always_comb begin
        w_en_pad   = '0;
        w_rise_pad = '0;
        w_en_pad[mrcd_pkg::ENABLE_BITS-1:0]   = r_enable;
        w_rise_pad[mrcd_pkg::ENABLE_BITS-1:0] =
            i_cfg_data[mrcd_pkg::ENABLE_BITS-1:0] & ~r_enable;
        for (int r = 0; r < mrcd_pkg::MAX_RINGS; r++) begin
            w_ring_on[r] = (r < RING_COUNT) && w_en_pad[r];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_q      = RING_W'(i_in_word.queue_index);
    assign w_q_on   = w_ring_on[i_in_word.queue_index];
    assign w_q_full = w_q_on && (r_fill[w_q] == CNT_W'(RING_DEPTH));

    always_comb begin
        w_pick  = '0;
        w_found = 1'b0;
        for (int r = RING_COUNT - 1; r >= 0; r--) begin
            if (w_ring_on[r] && (r_fill[r] != '0)) begin
                w_pick  = RING_W'(r);
                w_found = 1'b1;
            end
        end
    end

    assign w_threshold = r_limit[7:1];
    assign w_can = w_found && (r_outstanding < w_threshold)
                   && (r_dispatched < mrcd_pkg::RESULT_CNT_W'(mrcd_pkg::MAX_RESULTS));

    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_out_load = w_accept && (i_in_word.operation == mrcd_pkg::OP_SUBMIT);
            end
            S_PICK: begin
                w_out_load = !w_can && w_out_free;
            end
            S_DATA: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (i_in_word.completed_count >= r_outstanding) begin
            n_outstanding_sub = '0;
        end else begin
            n_outstanding_sub = r_outstanding - i_in_word.completed_count;
        end
    end

    always_comb begin
        w_mem_wdata.nsid = i_in_word.namespace_id;
        w_mem_wdata.tag  = i_in_word.request_tag;
        if ((i_in_word.command_kind == mrcd_pkg::KIND_FLUSH) ||
            (i_in_word.command_kind == mrcd_pkg::KIND_RESERVED)) begin
            w_mem_wdata.kind    = mrcd_pkg::KIND_FLUSH;
            w_mem_wdata.address = '0;
            w_mem_wdata.count   = '0;
        end else begin
            w_mem_wdata.kind    = i_in_word.command_kind;
            w_mem_wdata.address = i_in_word.block_address;
            w_mem_wdata.count   = i_in_word.block_count;
        end
    end

    assign w_mem_we    = w_accept && (i_in_word.operation == mrcd_pkg::OP_SUBMIT)
                         && w_q_on && !w_q_full;
    assign w_mem_waddr = {w_q, r_tail[w_q]};
    assign w_mem_re    = (r_state == S_PICK) && w_can;
    assign w_mem_raddr = {w_pick, r_head[w_pick]};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_rdata <= r_mem[w_mem_raddr];
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.outstanding = r_outstanding;
        n_out.last        = 1'b1;
        case (r_state)
            S_IDLE: begin
                n_out.source_queue = i_in_word.queue_index;
                if (!w_q_on) begin
                    n_out.result_kind = mrcd_pkg::RES_DISABLED;
                end else if (w_q_full) begin
                    n_out.result_kind = mrcd_pkg::RES_FULL;
                end else begin
                    n_out.result_kind = mrcd_pkg::RES_ACCEPTED;
                end
            end
            S_DATA: begin
                n_out.result_kind      = mrcd_pkg::RES_DISPATCHED;
                n_out.source_queue     = r_src;
                n_out.issued_kind      = r_mem_rdata.kind;
                n_out.issued_address   = r_mem_rdata.address;
                n_out.issued_count     = r_mem_rdata.count;
                n_out.issued_namespace = r_mem_rdata.nsid;
                n_out.issued_tag       = r_mem_rdata.tag;
                n_out.last             = !w_can;
            end
            default: begin
                n_out.result_kind = mrcd_pkg::RES_NOTHING;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_limit       <= mrcd_pkg::LIMIT_RESET;
            r_enable      <= '0;
            r_outstanding <= '0;
            r_dispatched  <= '0;
            r_src         <= '0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
            for (int r = 0; r < RING_COUNT; r++) begin
                r_head[r] <= '0;
                r_tail[r] <= '0;
                r_fill[r] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mrcd_pkg::CFG_OUTSTANDING_LIMIT: begin
                        r_limit <= i_cfg_data;
                    end
                    mrcd_pkg::CFG_QUEUE_ENABLE: begin
                        r_enable <= i_cfg_data[mrcd_pkg::ENABLE_BITS-1:0];
                        for (int r = 0; r < RING_COUNT; r++) begin
                            if (w_rise_pad[r]) begin
                                r_head[r] <= '0;
                                r_tail[r] <= '0;
                                r_fill[r] <= '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_word.operation == mrcd_pkg::OP_SUBMIT) begin
                            if (w_mem_we) begin
                                r_fill[w_q] <= r_fill[w_q] + CNT_W'(1);
                                if (r_tail[w_q] == PTR_W'(RING_DEPTH - 1)) begin
                                    r_tail[w_q] <= '0;
                                end else begin
                                    r_tail[w_q] <= r_tail[w_q] + PTR_W'(1);
                                end
                            end
                        end else begin
                            r_outstanding <= n_outstanding_sub;
                            r_dispatched  <= '0;
                            r_state       <= S_PICK;
                        end
                    end
                end
                S_PICK: begin
                    if (w_can) begin
                        r_src         <= 2'(w_pick);
                        r_fill[w_pick] <= r_fill[w_pick] - CNT_W'(1);
                        if (r_head[w_pick] == PTR_W'(RING_DEPTH - 1)) begin
                            r_head[w_pick] <= '0;
                        end else begin
                            r_head[w_pick] <= r_head[w_pick] + PTR_W'(1);
                        end
                        r_outstanding <= r_outstanding + mrcd_pkg::OUTSTANDING_W'(1);
                        r_dispatched  <= r_dispatched + mrcd_pkg::RESULT_CNT_W'(1);
                        r_state       <= S_DATA;
                    end else if (w_out_free) begin
                        r_state     <= S_IDLE;
                    end
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_state     <= w_can ? S_PICK : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_dispatch_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dispatched <= mrcd_pkg::RESULT_CNT_W'(mrcd_pkg::MAX_RESULTS))
        else $error("dispatch count exceeded the per-poll cap");

    a_pick_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && w_can) |=> (r_state == S_DATA))
        else $error("slot read was not followed by its data cycle");

    a_open_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state != S_IDLE))
        else $error("non-final word pending while idle");

    a_port_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("slot memory written and read in the same cycle");

    a_dispatch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && w_can) |=> (r_outstanding <= w_threshold))
        else $error("outstanding count passed the dispatch threshold");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 16;
    localparam int RING_COUNT  = 4;
    localparam int SLOT_TOTAL  = RING_DEPTH * RING_COUNT;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    mrcd_pkg::t_in_word   in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    mrcd_pkg::t_out_word  out_word;
    logic                 cfg_wr_en = 1'b0;
    logic [mrcd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mrcd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow of the dispatcher state, kept in step with accepted words.
    logic             slot_full [SLOT_TOTAL];
    mrcd_pkg::t_slot  slot_data [SLOT_TOTAL];
    logic [3:0]       ring_head [RING_COUNT];
    logic [3:0]       ring_tail [RING_COUNT];
    logic [6:0]       shadow_outstanding;
    logic [7:0]       shadow_limit;
    logic [3:0]       shadow_enable;

    mrcd_pkg::t_out_word  awaited_results[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  results_seen = 0;
    int  kind_seen [5] = '{default: 0};
    int  longest_hold = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    multi_ring_command_dispatcher_unit #(
        .RING_DEPTH(RING_DEPTH),
        .RING_COUNT(RING_COUNT)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d words still awaited.",
                     cycle_count, awaited_results.size());
            $display("[multi_ring_command_dispatcher_unit] ERROR");
            $finish;
        end
    end

    function automatic void add_awaited(mrcd_pkg::t_out_word res);
        awaited_results = {awaited_results, res};
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < SLOT_TOTAL; i++) begin
            slot_full[i] = 1'b0;
            slot_data[i] = '0;
        end
        for (int r = 0; r < RING_COUNT; r++) begin
            ring_head[r] = '0;
            ring_tail[r] = '0;
        end
        shadow_outstanding = '0;
        shadow_limit = mrcd_pkg::LIMIT_RESET;
        shadow_enable = '0;
    endfunction

    function automatic void apply_config(logic [mrcd_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [7:0] data);
        logic [3:0] rising;
        if (idx == mrcd_pkg::CFG_OUTSTANDING_LIMIT) begin
            shadow_limit = data;
        end else begin
            rising = data[3:0] & ~shadow_enable;
            shadow_enable = data[3:0];
            // A ring that is switched back on loses whatever it held.
            for (int r = 0; r < RING_COUNT; r++) begin
                if (rising[r]) begin
                    ring_head[r] = '0;
                    ring_tail[r] = '0;
                    for (int i = 0; i < RING_DEPTH; i++) begin
                        slot_full[r * RING_DEPTH + i] = 1'b0;
                    end
                end
            end
        end
    endfunction

    function automatic void predict_results(mrcd_pkg::t_in_word w);
        mrcd_pkg::t_out_word  res;
        mrcd_pkg::t_out_word  held;
        int         slot;
        int         ring;
        int         issued;
        int         threshold;
        bit         found;
        bit         have_held;
        logic [1:0] kind;
        res = '0;
        held = '0;
        if (w.operation == mrcd_pkg::OP_SUBMIT) begin
            res.source_queue = w.queue_index;
            if (!shadow_enable[w.queue_index]) begin
                res.result_kind = mrcd_pkg::RES_DISABLED;
            end else begin
                slot = w.queue_index * RING_DEPTH + ring_tail[w.queue_index];
                if (slot_full[slot]) begin
                    res.result_kind = mrcd_pkg::RES_FULL;
                end else begin
                    kind = (w.command_kind == mrcd_pkg::KIND_RESERVED) ?
                           mrcd_pkg::KIND_FLUSH : w.command_kind;
                    slot_data[slot].kind = kind;
                    slot_data[slot].nsid = w.namespace_id;
                    slot_data[slot].tag = w.request_tag;
                    slot_data[slot].address =
                        (kind == mrcd_pkg::KIND_FLUSH) ? '0 : w.block_address;
                    slot_data[slot].count =
                        (kind == mrcd_pkg::KIND_FLUSH) ? '0 : w.block_count;
                    slot_full[slot] = 1'b1;
                    ring_tail[w.queue_index] = (ring_tail[w.queue_index] + 1) % RING_DEPTH;
                    res.result_kind = mrcd_pkg::RES_ACCEPTED;
                end
            end
            res.outstanding = shadow_outstanding;
            res.last = 1'b1;
            add_awaited(res);
            return;
        end
        if (shadow_outstanding != 0) begin
            shadow_outstanding = (w.completed_count >= shadow_outstanding) ?
                                 7'd0 : shadow_outstanding - w.completed_count;
        end
        threshold = shadow_limit / 2;
        issued = 0;
        have_held = 1'b0;
        while (issued < mrcd_pkg::MAX_RESULTS && int'(shadow_outstanding) < threshold) begin
            found = 1'b0;
            for (ring = 0; ring < RING_COUNT && !found; ring++) begin
                slot = ring * RING_DEPTH + ring_head[ring];
                if (shadow_enable[ring] && slot_full[slot]) begin
                    found = 1'b1;
                    slot_full[slot] = 1'b0;
                    ring_head[ring] = (ring_head[ring] + 1) % RING_DEPTH;
                    shadow_outstanding = shadow_outstanding + 7'd1;
                    if (have_held) begin
                        add_awaited(held);
                    end
                    held = '0;
                    held.result_kind = mrcd_pkg::RES_DISPATCHED;
                    held.source_queue = ring[1:0];
                    held.issued_kind = slot_data[slot].kind;
                    held.issued_address = slot_data[slot].address;
                    held.issued_count = slot_data[slot].count;
                    held.issued_namespace = slot_data[slot].nsid;
                    held.issued_tag = slot_data[slot].tag;
                    held.outstanding = shadow_outstanding;
                    have_held = 1'b1;
                    issued++;
                end
            end
            if (!found) begin
                break;
            end
        end
        if (!have_held) begin
            held.result_kind = mrcd_pkg::RES_NOTHING;
            held.outstanding = shadow_outstanding;
        end
        held.last = 1'b1;
        add_awaited(held);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("Mismatch at cycle %0d: %s is %0h, should be %0h",
                 cycle_count, what, got, want);
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge clk) begin : result_checker
        mrcd_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (out_word.result_kind <= mrcd_pkg::RES_NOTHING) begin
                kind_seen[int'(out_word.result_kind)]++;
            end
            if (awaited_results.size() == 0) begin
                report_mismatch("unrequested word, kind", 64'(out_word.result_kind), '0);
            end else begin
                want = awaited_results.pop_front();
                compare_field("result_kind", 64'(out_word.result_kind),
                              64'(want.result_kind));
                compare_field("source_queue", 64'(out_word.source_queue),
                              64'(want.source_queue));
                compare_field("issued_kind", 64'(out_word.issued_kind), 64'(want.issued_kind));
                compare_field("issued_address", out_word.issued_address, want.issued_address);
                compare_field("issued_count", 64'(out_word.issued_count),
                              64'(want.issued_count));
                compare_field("issued_namespace", 64'(out_word.issued_namespace),
                              64'(want.issued_namespace));
                compare_field("issued_tag", 64'(out_word.issued_tag), 64'(want.issued_tag));
                compare_field("outstanding", 64'(out_word.outstanding), 64'(want.outstanding));
                compare_field("last", 64'(out_word.last), 64'(want.last));
            end
        end
    end

    initial begin : result_receiver
        int gap;
        int hold_len;
        wait (rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold_len = rx_hold_cycles;
                rx_hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                if (hold_len > longest_hold) begin
                    longest_hold = hold_len;
                end
            end
            gap = rx_idle_on ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic send_word(mrcd_pkg::t_in_word w);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 17) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!in_ready);
        predict_results(w);
        words_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(logic [mrcd_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        apply_config(idx, data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic mrcd_pkg::t_in_word random_word(logic op);
        mrcd_pkg::t_in_word w;
        w.operation = op;
        w.queue_index = 2'($urandom_range(0, 3));
        w.command_kind = 2'($urandom_range(0, 3));
        w.block_address = {$urandom, $urandom};
        w.block_count = $urandom;
        w.namespace_id = $urandom;
        w.request_tag = 16'($urandom);
        w.completed_count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64)) :
                                                          7'($urandom_range(0, 4));
        return w;
    endfunction

    function automatic mrcd_pkg::t_in_word submit_to(int ring, logic [1:0] kind);
        mrcd_pkg::t_in_word w;
        w = random_word(mrcd_pkg::OP_SUBMIT);
        w.queue_index = 2'(ring);
        w.command_kind = kind;
        return w;
    endfunction

    function automatic mrcd_pkg::t_in_word poll_with(int done);
        mrcd_pkg::t_in_word w;
        w = random_word(mrcd_pkg::OP_POLL);
        w.completed_count = 7'(done);
        return w;
    endfunction

    task automatic test_after_reset();
        send_word(random_word(mrcd_pkg::OP_SUBMIT));
        send_word(poll_with(5));
        wait_idle();
    endtask

    task automatic test_command_kinds();
        mrcd_pkg::t_in_word w;
        cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h0F);
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, mrcd_pkg::LIMIT_RESET);
        // Submitted from the lowest priority ring upwards; dispatch must reverse this.
        w = submit_to(3, mrcd_pkg::KIND_READ);
        w.block_address = '1;
        w.block_count = '1;
        w.namespace_id = '1;
        w.request_tag = '1;
        w.completed_count = 7'h7F;
        send_word(w);
        w = submit_to(2, mrcd_pkg::KIND_WRITE);
        w.block_address = '0;
        w.block_count = '0;
        w.namespace_id = '0;
        w.request_tag = '0;
        w.completed_count = '0;
        send_word(w);
        send_word(submit_to(1, mrcd_pkg::KIND_FLUSH));
        send_word(submit_to(0, mrcd_pkg::KIND_RESERVED));
        send_word(poll_with(0));
        send_word(poll_with(64));
        wait_idle();
    endtask

    task automatic test_small_limit();
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, 8'd1);
        send_word(submit_to(0, mrcd_pkg::KIND_WRITE));
        send_word(poll_with(0));
        wait_idle();
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, 8'd0);
        send_word(poll_with(0));
        wait_idle();
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, 8'd2);
        send_word(submit_to(0, mrcd_pkg::KIND_READ));
        send_word(poll_with(0));
        send_word(poll_with(0));
        send_word(poll_with(1));
        wait_idle();
    endtask

    task automatic test_disable();
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, mrcd_pkg::LIMIT_RESET);
        send_word(submit_to(1, mrcd_pkg::KIND_READ));
        wait_idle();
        cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h0D);
        send_word(submit_to(1, mrcd_pkg::KIND_WRITE));
        send_word(poll_with(64));
        wait_idle();
        cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h0F);
        send_word(poll_with(0));
        wait_idle();
    endtask

    task automatic test_full_rings();
        cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h00);
        cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h0F);
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, 8'd0);
        send_word(poll_with(64));
        wait_idle();
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, mrcd_pkg::LIMIT_RESET);
        for (int i = 0; i < (RING_DEPTH + 1) * RING_COUNT; i++) begin
            send_word(submit_to(i % RING_COUNT, 2'($urandom_range(0, 3))));
        end
        // Every ring is full, so one poll hits the per-word dispatch ceiling.
        send_word(poll_with(0));
        send_word(poll_with(0));
        send_word(poll_with(64));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        mrcd_pkg::t_in_word w;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, mrcd_pkg::LIMIT_RESET);
                1: cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, 8'd2);
                default: cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT,
                                   8'($urandom_range(2, 128)));
            endcase
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h0F);
            end else begin
                cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'($urandom_range(0, 15)));
            end
            tx_idle_on = (phase != 1 && phase != 4);
            rx_idle_on = (phase != 2 && phase != 4);
            for (int i = 0; i < 40; i++) begin
                w = random_word(($urandom_range(0, 9) < 7) ? mrcd_pkg::OP_SUBMIT :
                                                             mrcd_pkg::OP_POLL);
                send_word(w);
            end
            wait_idle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        cfg_write(mrcd_pkg::CFG_QUEUE_ENABLE, 8'h0F);
        cfg_write(mrcd_pkg::CFG_OUTSTANDING_LIMIT, mrcd_pkg::LIMIT_RESET);
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 24; i++) begin
            send_word((i % 4 == 3) ? poll_with($urandom_range(0, 8)) :
                                     random_word(mrcd_pkg::OP_SUBMIT));
        end
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    initial begin
        shadow_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_command_kinds();
        test_small_limit();
        test_disable();
        test_full_rings();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d command and poll words, checked %0d results in %0d cycles.",
                 words_sent, results_seen, cycle_count);
        $display("Accepted %0d, full %0d, disabled %0d, dispatched %0d, empty polls %0d; %s",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 $sformatf("longest output stall %0d cycles.", longest_hold));
        if (error_count == 0) begin
            $display("[multi_ring_command_dispatcher_unit] OK");
        end else begin
            $display("[multi_ring_command_dispatcher_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ multi_ring_command_dispatcher_unit.f @@
hdl/mrcd_pkg.sv
hdl/multi_ring_command_dispatcher_unit.sv
bench/tb_top.sv
